/* rtl/gpr_pkg.sv */
// Shared types and constants for the GPIO per-pin register block.
// Used by gpr_addr_decode, gpr_pin_regs and gpio_port_registers_core.
package gpr_pkg;

    // Number of pins served (1 to 8)
    localparam int PIN_COUNT = 8;

    // Register bit positions
    localparam int BIT_DATA   = 0;
    localparam int BIT_DIR    = 1;
    localparam int BIT_STATUS = 8;
    localparam int BIT_ENABLE = 9;

    // Mask of the register bits that can read as one
    localparam logic [31:0] READ_MASK = (32'd1 << BIT_DATA) | (32'd1 << BIT_DIR)
                                      | (32'd1 << BIT_STATUS) | (32'd1 << BIT_ENABLE);

    // Byte offset of each pin register; 0x18 is a hole
    localparam logic [7:0] REG_OFFSET [8] = '{
        8'h00, 8'h04, 8'h08, 8'h0c, 8'h10, 8'h14, 8'h1c, 8'h20
    };

    // Operation codes
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // One input word
    typedef struct packed {
        op_t         operation;
        logic [7:0]  address;
        logic [31:0] bus_wdata;
        logic [7:0]  pin_levels;
    } item_t;

    // Address decode result
    typedef struct packed {
        logic                 hit;
        logic [PIN_COUNT-1:0] sel;
    } dec_t;

    // One result word
    typedef struct packed {
        logic [31:0] bus_rdata;
        logic        bad_address;
        logic        irq;
        logic [7:0]  pin_drive;
        logic [7:0]  pin_drive_enable;
    } result_t;

endpackage

/* rtl/gpio_port_registers_core.sv */
// GPIO per-pin register block, top level.
// A word passes through the input register, then the output register, and leaves
// when m_axis_tready is high. Throughput: one word per cycle while m_axis_tready
// is high; the output register lets a new word enter while a result waits, and
// pin state updates as a word leaves the input register.
// Reset (rst_n low, asynchronous) clears all pin state and both valid flags.
// Depends on gpr_pkg, gpr_addr_decode and gpr_pin_regs.
module gpio_port_registers_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[7:0], bus_wdata[39:8], pin_levels[47:40]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // bus_rdata[31:0], bad_address[32], irq[33],
                                        // pin_drive[41:34], pin_drive_enable[49:42], zero pad
);
    import gpr_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    out_free;
    logic    advance;
    dec_t    dec;
    result_t result;

    // Handshake control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.operation  <= op_t'(s_axis_tuser);
            in_item_reg.address    <= s_axis_tdata[7:0];
            in_item_reg.bus_wdata  <= s_axis_tdata[39:8];
            in_item_reg.pin_levels <= s_axis_tdata[47:40];
        end
    end

    gpr_addr_decode u_decode (
        .address (in_item_reg.address),
        .dec     (dec)
    );

    gpr_pin_regs u_pins (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .item   (in_item_reg),
        .dec    (dec),
        .result (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_result_reg.pin_drive_enable,
                            out_result_reg.pin_drive,
                            out_result_reg.irq,
                            out_result_reg.bad_address,
                            out_result_reg.bus_rdata};

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while a stage was free");

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("bad address result carries read data");

    a_reserved_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[31:0] & ~READ_MASK) == 32'd0))
        else $error("reserved read bits set");

endmodule

/* rtl/gpr_addr_decode.sv */
// Address decoder: maps a byte offset onto a one-hot pin select.
// Depends on gpr_pkg.
module gpr_addr_decode (
    input  logic [7:0]  address,
    output gpr_pkg::dec_t dec
);
    import gpr_pkg::*;

    // Compare against every pin's offset
    always_comb
    begin
        dec.sel = '0;
        for (int p = 0; p < PIN_COUNT; p++)
        begin
            dec.sel[p] = (address == REG_OFFSET[p]);
        end
        dec.hit = |dec.sel;
    end

endmodule

/* rtl/gpr_pin_regs.sv */
// Per-pin state (latch, direction, enable, status, last level) and the
// result logic for one word. Depends on gpr_pkg.
module gpr_pin_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  gpr_pkg::item_t    item,
    input  gpr_pkg::dec_t     dec,
    output gpr_pkg::result_t  result
);
    import gpr_pkg::*;

    logic [PIN_COUNT-1:0] output_latch_reg, output_latch_next;
    logic [PIN_COUNT-1:0] direction_reg, direction_next;
    logic [PIN_COUNT-1:0] enable_reg, enable_next;
    logic [PIN_COUNT-1:0] status_reg, status_next;
    logic [PIN_COUNT-1:0] last_levels_reg, last_levels_next;
    logic [PIN_COUNT-1:0] levels;
    logic [PIN_COUNT-1:0] rise;
    logic                 is_access;
    logic                 rd_data, rd_dir, rd_status, rd_enable;

    assign levels    = item.pin_levels[PIN_COUNT-1:0];
    assign rise      = levels & ~last_levels_reg;
    assign is_access = (item.operation == OP_READ) || (item.operation == OP_WRITE);

    // Next state
    always_comb
    begin
        output_latch_next = output_latch_reg;
        direction_next    = direction_reg;
        enable_next       = enable_reg;
        status_next       = status_reg;
        last_levels_next  = last_levels_reg;
        unique case (item.operation)
            OP_WRITE:
            begin
                if (dec.hit)
                begin
                    output_latch_next = (output_latch_reg & ~dec.sel)
                                      | (dec.sel & {PIN_COUNT{item.bus_wdata[BIT_DATA]}});
                    direction_next    = (direction_reg & ~dec.sel)
                                      | (dec.sel & {PIN_COUNT{item.bus_wdata[BIT_DIR]}});
                    enable_next       = (enable_reg & ~dec.sel)
                                      | (dec.sel & {PIN_COUNT{item.bus_wdata[BIT_ENABLE]}});
                    if (item.bus_wdata[BIT_STATUS])
                    begin
                        status_next = status_reg & ~dec.sel;
                    end
                end
            end
            OP_SAMPLE:
            begin
                // rising edge on an armed input pin latches status
                status_next      = status_reg | (rise & enable_reg & ~direction_reg);
                last_levels_next = levels;
            end
            OP_READ, OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_latch_reg <= '0;
            direction_reg    <= '0;
            enable_reg       <= '0;
            status_reg       <= '0;
            last_levels_reg  <= '0;
        end
        else if (update)
        begin
            output_latch_reg <= output_latch_next;
            direction_reg    <= direction_next;
            enable_reg       <= enable_next;
            status_reg       <= status_next;
            last_levels_reg  <= last_levels_next;
        end
    end

    // Selected pin's bits for a read
    assign rd_dir    = |(dec.sel & direction_reg);
    assign rd_data   = |(dec.sel & ((direction_reg & output_latch_reg)
                                  | (~direction_reg & last_levels_reg)));
    assign rd_status = |(dec.sel & status_reg);
    assign rd_enable = |(dec.sel & enable_reg);

    // Result word, status and drive taken after this word's update
    always_comb
    begin
        result                  = '0;
        result.bad_address      = is_access && !dec.hit;
        if (item.operation == OP_READ && dec.hit)
        begin
            result.bus_rdata[BIT_DATA]   = rd_data;
            result.bus_rdata[BIT_DIR]    = rd_dir;
            result.bus_rdata[BIT_STATUS] = rd_status;
            result.bus_rdata[BIT_ENABLE] = rd_enable;
        end
        result.irq                             = |(status_next & enable_next);
        result.pin_drive[PIN_COUNT-1:0]        = output_latch_next;
        result.pin_drive_enable[PIN_COUNT-1:0] = direction_next;
    end

endmodule

/* tb/sv/tb_gpio_port_registers_core.sv */
// Testbench for gpio_port_registers_core: directed table, then random bus and sample words.
// Every result word is checked against a local model of the pin registers or a typed-in expected word.
// Depends on gpr_pkg and the RTL of the block.
module tb_gpio_port_registers_core;

    import gpr_pkg::*;

    localparam int          RANDOM_WORDS = 1000;
    localparam int          CALM_WORDS   = 150;   // tail of the run without idling or stalls
    localparam logic [7:0]  PIN_MASK     = 8'hFF >> (8 - PIN_COUNT);

    // Results that can be typed in directly while all pin state is still at reset
    localparam result_t ZERO_AT_RESET = '0;
    localparam result_t BAD_AT_RESET  = '{32'd0, 1'b1, 1'b0, 8'd0, 8'd0};

    typedef struct {
        op_t         op;
        logic [7:0]  addr;
        logic [31:0] wdata;
        logic [7:0]  levels;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // address[7:0], bus_wdata[39:8], pin_levels[47:40]
    logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // bus_rdata[31:0], bad_address[32], irq[33],
                                      // pin_drive[41:34], pin_drive_enable[49:42]

    // Model copy of the pin state
    logic [7:0]  drive_latch = '0;
    logic [7:0]  dir_mask    = '0;
    logic [7:0]  irq_enable  = '0;
    logic [7:0]  irq_status  = '0;
    logic [7:0]  level_seen  = '0;

    result_t     expected_words [$];
    stim_row_t   directed_rows [$];
    int          error_count = 0;
    bit          calm_tail = 1'b0;
    int          stall_left = 0;
    result_t     got_word;
    result_t     want_word;

    gpio_port_registers_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expected result word of one input word; updates the model pin state
    function automatic result_t pin_reg_result(op_t op, logic [7:0] addr,
                                               logic [31:0] wdata, logic [7:0] lv);
        result_t    r;
        int         pin;
        logic [7:0] levels;
        r      = '0;
        pin    = -1;
        levels = lv & PIN_MASK;
        if (op == OP_READ || op == OP_WRITE)
        begin
            for (int p = 0; p < PIN_COUNT; p++)
                if (REG_OFFSET[p] == addr)
                    pin = p;
            if (pin < 0)
                r.bad_address = 1'b1;
            else if (op == OP_READ)
            begin
                // data bit mirrors the latch for outputs, the sampled level for inputs
                r.bus_rdata[BIT_DATA]   = dir_mask[pin] ? drive_latch[pin] : level_seen[pin];
                r.bus_rdata[BIT_DIR]    = dir_mask[pin];
                r.bus_rdata[BIT_STATUS] = irq_status[pin];
                r.bus_rdata[BIT_ENABLE] = irq_enable[pin];
            end
            else
            begin
                drive_latch[pin] = wdata[BIT_DATA];
                dir_mask[pin]    = wdata[BIT_DIR];
                irq_enable[pin]  = wdata[BIT_ENABLE];
                if (wdata[BIT_STATUS])
                    irq_status[pin] = 1'b0;
            end
        end
        else if (op == OP_SAMPLE)
        begin
            // rising edge on an enabled input pin latches status
            irq_status = (irq_status | (levels & ~level_seen & irq_enable & ~dir_mask))
                         & PIN_MASK;
            level_seen = levels;
        end
        r.irq              = |(irq_status & irq_enable & PIN_MASK);
        r.pin_drive        = drive_latch & PIN_MASK;
        r.pin_drive_enable = dir_mask & PIN_MASK;
        return r;
    endfunction

    // Present one word, wait for the handshake, then queue its expected result
    task automatic send_word(input op_t op, input logic [7:0] addr, input logic [31:0] wdata,
                             input logic [7:0] lv, input bit typed, input result_t want);
        result_t pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lv, wdata, addr};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = pin_reg_result(op, addr, wdata, lv);
        expected_words.push_back(typed ? want : pred);
    endtask

    // Sender idle burst, only outside the calm tail
    task automatic maybe_idle();
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // Receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            stall_left    = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_word = '{m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33],
                         m_axis_tdata[41:34], m_axis_tdata[49:42]};
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word.bus_rdata !== want_word.bus_rdata)
                begin
                    $display("%0t: bus_rdata expected %h actual %h", $time,
                             want_word.bus_rdata, got_word.bus_rdata);
                    error_count++;
                end
                if (got_word.bad_address !== want_word.bad_address)
                begin
                    $display("%0t: bad_address expected %b actual %b", $time,
                             want_word.bad_address, got_word.bad_address);
                    error_count++;
                end
                if (got_word.irq !== want_word.irq)
                begin
                    $display("%0t: irq expected %b actual %b", $time,
                             want_word.irq, got_word.irq);
                    error_count++;
                end
                if (got_word.pin_drive !== want_word.pin_drive)
                begin
                    $display("%0t: pin_drive expected %h actual %h", $time,
                             want_word.pin_drive, got_word.pin_drive);
                    error_count++;
                end
                if (got_word.pin_drive_enable !== want_word.pin_drive_enable)
                begin
                    $display("%0t: pin_drive_enable expected %h actual %h", $time,
                             want_word.pin_drive_enable, got_word.pin_drive_enable);
                    error_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        op_t         op;
        logic [7:0]  addr;
        logic [31:0] wdata;
        int          pick;

        // reset state, unmapped offsets, no-op word
        directed_rows.push_back('{OP_READ,   8'h00, 32'h0000_0000, 8'h00, 1'b1, ZERO_AT_RESET});
        directed_rows.push_back('{OP_READ,   8'h18, 32'h0000_0000, 8'h00, 1'b1, BAD_AT_RESET});
        directed_rows.push_back('{OP_WRITE,  8'h18, 32'hFFFF_FFFF, 8'hFF, 1'b1, BAD_AT_RESET});
        directed_rows.push_back('{OP_READ,   8'hFF, 32'h0000_0000, 8'h00, 1'b1, BAD_AT_RESET});
        directed_rows.push_back('{OP_WRITE,  8'h02, 32'hFFFF_FFFF, 8'h00, 1'b1, BAD_AT_RESET});
        directed_rows.push_back('{OP_READ,   8'h24, 32'h0000_0000, 8'h00, 1'b1, BAD_AT_RESET});
        directed_rows.push_back('{OP_NONE,   8'h00, 32'hFFFF_FFFF, 8'hFF, 1'b1, ZERO_AT_RESET});
        // output pin with enable set, two armed inputs
        directed_rows.push_back('{OP_WRITE,  8'h00, 32'h0000_0203, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE,  8'h20, 32'h0000_0200, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE,  8'h1c, 32'h0000_0200, 8'h00, 1'b0, '0});
        // sample ignores address and write data; edge on output pin sets nothing
        directed_rows.push_back('{OP_SAMPLE, 8'h18, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h20, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h1c, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h00, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_SAMPLE, 8'h00, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_SAMPLE, 8'hFF, 32'h0000_0000, 8'hFF, 1'b0, '0});
        // status clear with and without enable, write with status bit low
        directed_rows.push_back('{OP_WRITE,  8'h20, 32'h0000_0100, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE,  8'h1c, 32'h0000_0200, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE,  8'h1c, 32'h0000_0300, 8'h00, 1'b0, '0});
        // all bits set, then only the ignored bits set
        directed_rows.push_back('{OP_WRITE,  8'h04, 32'hFFFF_FFFF, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h04, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE,  8'h08, 32'hFFFF_FCFC, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h08, 32'h0000_0000, 8'h00, 1'b0, '0});
        directed_rows.push_back('{OP_SAMPLE, 8'h14, 32'h1234_5678, 8'hAA, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   8'h14, 32'h0000_0000, 8'h00, 1'b0, '0});

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].wdata,
                      directed_rows[i].levels, directed_rows[i].typed, directed_rows[i].want);
            maybe_idle();
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n >= RANDOM_WORDS - CALM_WORDS)
                calm_tail = 1'b1;
            // hold off until the pipeline has drained once
            if (n == RANDOM_WORDS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_words.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = OP_READ;
            else if (pick < 70)
                op = OP_WRITE;
            else if (pick < 95)
                op = OP_SAMPLE;
            else
                op = OP_NONE;
            // mostly mapped offsets, some arbitrary ones
            if ($urandom_range(0, 99) < 85)
                addr = REG_OFFSET[$urandom_range(0, 7)];
            else
                addr = 8'($urandom_range(0, 255));
            wdata = $urandom;
            if ($urandom_range(0, 1) == 0)
                wdata = wdata & READ_MASK;
            send_word(op, addr, wdata, 8'($urandom_range(0, 255)), 1'b0, '0);
            maybe_idle();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
